// File: design/fragment_reassembly_checker_defines.svh
// Assertion macros used by the verification-side checker (frc_checker) of the fragment reassembly checker.
// Needs signals named clk and rst in the scope where a macro is used.
`ifndef FRAGMENT_REASSEMBLY_CHECKER_DEFINES_SVH
`define FRAGMENT_REASSEMBLY_CHECKER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FRC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define FRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/frc_pkg.sv
// Package for the fragment reassembly checker: payload structs, request and status codes,
// queue control struct and engine states. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package frc_pkg;

  localparam logic [22:0] CK_MOD = 23'd8388607;

  localparam logic [1:0] REQ_BYTE    = 2'd0;
  localparam logic [1:0] REQ_READ    = 2'd1;
  localparam logic [1:0] REQ_START   = 2'd2;
  localparam logic [1:0] REQ_IGNORED = 2'd3;

  localparam logic [2:0] ST_PROGRESS = 3'd0;
  localparam logic [2:0] ST_ACCEPT   = 3'd1;
  localparam logic [2:0] ST_CKERR    = 3'd2;
  localparam logic [2:0] ST_RANGE    = 3'd3;
  localparam logic [2:0] ST_READ     = 3'd4;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  data_byte;
    logic [11:0] read_index;
  } frc_in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [12:0]        words_written;
    logic [31:0]        total_written;
    logic [22:0]        computed_checksum;
    logic signed [31:0] read_data;
  } frc_out_t;

  typedef enum logic [1:0] {
    K_BYTE,
    K_READ,
    K_START,
    K_NOP
  } frc_kind_t;

  typedef struct packed {
    frc_kind_t   kind;
    logic [7:0]  data_byte;
    logic [11:0] read_index;
  } frc_cmd_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } frc_qctl_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SUM,
    S_FOLD,
    S_CHECK,
    S_COMMIT,
    S_DRAIN,
    S_RDWAIT,
    S_EMIT
  } frc_state_t;

endpackage

`default_nettype wire

// File: design/frc_front.sv
// Front part: accepts request items, classifies them and holds them in a two-entry queue.
// Depends on frc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module frc_front
  import frc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_ready,
  input  wire frc_in_t   req,
  input  wire frc_qctl_t qctl,
  output logic           q_valid,
  output frc_cmd_t       q_cmd
);

  frc_cmd_t   slot [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  frc_cmd_t   cmd_in;
  logic       push;

  always_comb begin
    case (req.req_type)
      REQ_BYTE:  cmd_in.kind = K_BYTE;
      REQ_READ:  cmd_in.kind = K_READ;
      REQ_START: cmd_in.kind = K_START;
      default:   cmd_in.kind = K_NOP;
    endcase
    cmd_in.data_byte  = req.data_byte;
    cmd_in.read_index = req.read_index;
  end

  assign req_ready = (count != 2'd2) && !qctl.clearing;
  assign push      = req_valid && req_ready;
  assign q_valid   = (count != 2'd0);
  assign q_cmd     = slot[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (qctl.pop) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, push} - {1'b0, qctl.pop};
    end
  end

endmodule

`default_nettype wire

// File: design/frc_back.sv
// Back part: header unpacking, payload buffering, checksum, commit loop, store reads.
// Holds the payload buffer and reconstruction store memories. Depends on frc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module frc_back
  import frc_pkg::*;
#(
  parameter int ARRAY_DEPTH   = 4096,
  parameter int PAYLOAD_WORDS = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [12:0] store_len,
  input  wire logic        q_valid,
  input  wire frc_cmd_t    q_cmd,
  output frc_qctl_t        qctl,
  output logic             rsp_valid,
  input  wire logic        rsp_ready,
  output frc_out_t         rsp
);

  localparam int AW = (ARRAY_DEPTH > 1) ? $clog2(ARRAY_DEPTH) : 1;
  localparam int PW = (PAYLOAD_WORDS > 1) ? $clog2(PAYLOAD_WORDS) : 1;

  frc_state_t state, state_next;

  logic [31:0] pbuf  [PAYLOAD_WORDS];
  logic [31:0] store [ARRAY_DEPTH];
  logic [31:0] buf_q;
  logic [31:0] store_q;

  logic [13:0] pos;
  logic [7:0]  hdr [16];
  logic [22:0] acc;
  logic [31:0] wa;
  logic [31:0] running_total;
  logic [31:0] hsum;
  logic [22:0] hmod;
  logic [AW-1:0] clr_addr;
  logic [12:0] kcnt;
  logic [12:0] nwr;
  logic [11:0] target_q;
  logic        pipe_v;
  logic [AW-1:0] pipe_addr;
  logic        rd_oob;
  logic [2:0]  res_status;
  logic [12:0] res_words;
  logic [22:0] res_ck;
  logic [31:0] res_rd;

  logic        slot_free;
  logic        pop;
  logic        rd_en;
  logic        rsp_load;
  logic [7:0]  b;
  logic        is_hdr;
  logic [13:0] rel;
  logic [11:0] k;
  logic [31:0] wa_new;
  logic        word_done;
  logic        byte_last;
  logic [13:0] len;
  logic [11:0] w_raw;
  logic [12:0] nwords;
  logic [31:0] mag;
  logic [24:0] acc_r;
  logic [23:0] acc_f;
  logic [22:0] acc_step;
  logic [31:0] hsum_c;
  logic [23:0] hfold;
  logic [23:0] calc_s;
  logic [22:0] calc;
  logic [22:0] given;
  logic [11:0] target;
  logic [16:0] limit;
  logic [16:0] avail;
  logic [12:0] n;
  logic        ck_ok;
  logic        in_range;
  logic [32:0] rt_sum;

  function automatic logic [11:0] rel_words(input logic [13:0] l);
    logic [13:0] d;
    d = l - 14'd16;
    return d[13:2];
  endfunction

  assign slot_free = !rsp_valid || rsp_ready;
  assign pop       = (state == S_IDLE) && q_valid && slot_free;
  assign rd_en     = pop && (q_cmd.kind == K_READ);
  assign qctl.pop      = pop;
  assign qctl.clearing = (state == S_CLEAR);

  // Load a new result: every popped item except reads and packet-ending bytes, or an emit
  assign rsp_load = (pop && (q_cmd.kind != K_READ) && !((q_cmd.kind == K_BYTE) && byte_last))
                  || ((state == S_EMIT) && slot_free);

  // Byte position decode
  assign b         = q_cmd.data_byte;
  assign is_hdr    = (pos < 14'd16);
  assign rel       = pos - 14'd16;
  assign k         = rel[13:2];
  assign wa_new    = {wa[23:0], b};
  assign word_done = !is_hdr && (rel[1:0] == 2'b11);

  assign len    = {hdr[9][1:0], hdr[10], hdr[11][7:4]};
  assign w_raw  = (len < 14'd16) ? 12'd0 : rel_words(len);
  assign nwords = ({1'b0, w_raw} > 13'(PAYLOAD_WORDS)) ? 13'(PAYLOAD_WORDS) : {1'b0, w_raw};

  always_comb begin
    if (is_hdr) begin
      byte_last = (pos == 14'd15) && (nwords == 13'd0);
    end else begin
      byte_last = word_done && (({1'b0, k} + 13'd1) >= nwords);
    end
  end

  // Running checksum: fold |word| modulo 2^23-1 into the accumulator
  assign mag      = wa_new[31] ? (~wa_new + 32'd1) : wa_new;
  assign acc_r    = {2'b0, acc} + {2'b0, mag[22:0]} + {16'b0, mag[31:23]};
  assign acc_f    = {1'b0, acc_r[22:0]} + {22'b0, acc_r[24:23]};
  assign acc_step = (acc_f >= {1'b0, CK_MOD}) ? 23'(acc_f - {1'b0, CK_MOD}) : acc_f[22:0];

  assign hsum_c = {4'b0, hdr[0], hdr[1], hdr[2], hdr[3][7:4]}
                + {4'b0, hdr[3][3:0], hdr[4], hdr[5], hdr[6]}
                + {28'b0, hdr[7][7:4]}
                + {28'b0, hdr[7][3:0]}
                + {18'b0, hdr[8], hdr[9][7:2]}
                + {18'b0, len}
                + {27'b0, hdr[11][3:0], hdr[12][7]}
                + {30'b0, hdr[15][7:6]}
                + {26'b0, hdr[15][5:0]};
  assign hfold  = {1'b0, hsum[22:0]} + {15'b0, hsum[31:23]};

  assign calc_s   = {1'b0, hmod} + {1'b0, acc};
  assign calc     = (calc_s >= {1'b0, CK_MOD}) ? 23'(calc_s - {1'b0, CK_MOD}) : calc_s[22:0];
  assign given    = {hdr[12][6:0], hdr[13], hdr[14]};
  assign target   = {hdr[8], hdr[9][7:4]};
  assign limit    = ({4'b0, store_len} > 17'(ARRAY_DEPTH)) ? 17'(ARRAY_DEPTH) : {4'b0, store_len};
  assign in_range = ({5'b0, target} < limit);
  assign avail    = limit - {5'b0, target};
  assign n        = ({4'b0, nwords} < avail) ? nwords : avail[12:0];
  assign ck_ok    = (calc == given);
  assign rt_sum   = {1'b0, running_total} + {20'b0, n};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:  if (clr_addr == AW'(ARRAY_DEPTH - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (pop && (q_cmd.kind == K_BYTE) && byte_last) begin
          state_next = S_SUM;
        end else if (rd_en) begin
          state_next = S_RDWAIT;
        end
      end
      S_SUM:    state_next = S_FOLD;
      S_FOLD:   state_next = S_CHECK;
      S_CHECK:  state_next = (ck_ok && in_range && (n != 13'd0)) ? S_COMMIT : S_EMIT;
      S_COMMIT: if (kcnt == nwr) state_next = S_DRAIN;
      S_DRAIN:  state_next = S_EMIT;
      S_RDWAIT: state_next = S_EMIT;
      S_EMIT:   if (slot_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Memories
  always_ff @(posedge clk) begin
    if (pop && (q_cmd.kind == K_BYTE) && word_done) begin
      pbuf[PW'(k)] <= wa_new;
    end
    if (state == S_COMMIT) begin
      buf_q <= pbuf[PW'(kcnt)];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      store[clr_addr] <= 32'd0;
    end else if (pipe_v) begin
      store[pipe_addr] <= buf_q;
    end
    if (rd_en) begin
      store_q <= store[AW'(q_cmd.read_index)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos           <= 14'd0;
      acc           <= 23'd0;
      wa            <= 32'd0;
      running_total <= 32'd0;
      rsp_valid     <= 1'b0;
      clr_addr      <= '0;
      kcnt          <= 13'd0;
      pipe_v        <= 1'b0;
    end else begin
      pipe_v <= (state == S_COMMIT) && (kcnt != nwr);
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: clr_addr <= clr_addr + AW'(1);
        S_IDLE: begin
          if (pop) begin
            case (q_cmd.kind)
              K_BYTE: begin
                if (is_hdr) begin
                  hdr[pos[3:0]] <= b;
                end else begin
                  wa <= wa_new;
                end
                if (word_done) begin
                  acc <= acc_step;
                end
                if (byte_last) begin
                  pos <= 14'd0;
                end else begin
                  pos <= pos + 14'd1;
                  rsp <= '{status: ST_PROGRESS, words_written: 13'd0,
                           total_written: running_total, computed_checksum: 23'd0,
                           read_data: 32'sd0};
                end
              end
              K_READ: rd_oob <= ({20'b0, q_cmd.read_index} >= 32'(ARRAY_DEPTH));
              K_START: begin
                running_total <= 32'd0;
                pos           <= 14'd0;
                acc           <= 23'd0;
                wa            <= 32'd0;
                rsp           <= '{status: ST_PROGRESS, words_written: 13'd0,
                                   total_written: 32'd0, computed_checksum: 23'd0,
                                   read_data: 32'sd0};
              end
              default: begin
                rsp <= '{status: ST_PROGRESS, words_written: 13'd0,
                         total_written: running_total, computed_checksum: 23'd0,
                         read_data: 32'sd0};
              end
            endcase
          end
        end
        S_SUM:  hsum <= hsum_c;
        S_FOLD: hmod <= (hfold >= {1'b0, CK_MOD}) ? 23'(hfold - {1'b0, CK_MOD}) : hfold[22:0];
        S_CHECK: begin
          res_ck   <= calc;
          res_rd   <= 32'd0;
          acc      <= 23'd0;
          wa       <= 32'd0;
          kcnt     <= 13'd0;
          nwr      <= n;
          target_q <= target;
          if (!ck_ok) begin
            res_status <= ST_CKERR;
            res_words  <= 13'd0;
          end else if (!in_range) begin
            res_status <= ST_RANGE;
            res_words  <= 13'd0;
          end else begin
            res_status    <= ST_ACCEPT;
            res_words     <= n;
            running_total <= rt_sum[32] ? 32'hFFFF_FFFF : rt_sum[31:0];
          end
        end
        S_COMMIT: begin
          if (kcnt != nwr) begin
            kcnt      <= kcnt + 13'd1;
            pipe_addr <= AW'({2'b0, target_q} + {1'b0, kcnt});
          end
        end
        S_RDWAIT: begin
          res_status <= ST_READ;
          res_words  <= 13'd0;
          res_ck     <= 23'd0;
          res_rd     <= rd_oob ? 32'd0 : store_q;
        end
        S_EMIT: begin
          if (slot_free) begin
            rsp <= '{status: res_status, words_written: res_words,
                     total_written: running_total, computed_checksum: res_ck,
                     read_data: res_rd};
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/fragment_reassembly_checker.sv
// Top level of the fragment reassembly checker: configuration register, front queue, back engine.
// Depends on frc_pkg, frc_front and frc_back.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid/req_ready   | frc_in_t  (req_type, data_byte, read_index)
//   rsp     | out       | rsp_valid/rsp_ready   | frc_out_t (one result item per request item)
//   cfg     | in        | cfg_valid/cfg_ready   | cfg_data = store length (13 bits)
//
// A packet byte that does not end a packet yields a progress result when popped. A packet-ending byte
// passes through pop, SUM, FOLD, CHECK and emit when nothing is committed, and otherwise also
// through the commit loop over the single store write port, then drain, before the emit.
// A read passes through pop, RDWAIT and emit, using the registered store read.
// After reset the store is swept to zero, one entry a cycle over all ARRAY_DEPTH entries, while
// req_ready stays low; cfg writes are taken throughout. A stalled rsp holds the engine at its
// next result while the two-entry queue keeps taking items until it is full.
`timescale 1ns / 1ps
`default_nettype none

module fragment_reassembly_checker
  import frc_pkg::*;
#(
  parameter int ARRAY_DEPTH   = 4096,
  parameter int PAYLOAD_WORDS = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_ready,
  input  wire frc_in_t     req,
  output logic             rsp_valid,
  input  wire logic        rsp_ready,
  output frc_out_t         rsp,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [12:0] cfg_data
);

  logic [12:0] store_len;
  frc_qctl_t   qctl;
  logic        q_valid;
  frc_cmd_t    q_cmd;

  // Configuration is always ready; hold the store length until the next write.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      store_len <= 13'd4096;
    end else if (cfg_valid && cfg_ready) begin
      store_len <= cfg_data;
    end
  end

  // Front: classify request items and queue them.
  frc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .qctl      (qctl),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd)
  );

  // Back: unpack, checksum, commit and answer reads.
  frc_back #(
    .ARRAY_DEPTH   (ARRAY_DEPTH),
    .PAYLOAD_WORDS (PAYLOAD_WORDS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .store_len (store_len),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .qctl      (qctl),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

// File: design/frc_checker.sv
// Port-level checker for the fragment reassembly checker, bound to the top level.
// Depends on frc_pkg and fragment_reassembly_checker_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "fragment_reassembly_checker_defines.svh"

module frc_checker
  import frc_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire frc_in_t     req,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire frc_out_t    rsp,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready,
  input wire logic [12:0] cfg_data
);

  `FRC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "rsp dropped while stalled")
  `FRC_ASSERT_NOW(a_rd_zero, rsp_valid && (rsp.status != ST_READ), rsp.read_data == 32'sd0, "read data on non-read result")
  `FRC_ASSERT_NOW(a_words_acc, rsp_valid && (rsp.status != ST_ACCEPT), rsp.words_written == 13'd0, "words written without accept")
  `FRC_ASSERT_NOW(a_ck_range, rsp_valid, rsp.computed_checksum != 23'h7FFFFF, "checksum not reduced")

endmodule

bind fragment_reassembly_checker frc_checker u_frc_checker (.*);

`default_nettype wire

// File: test/fragment_reassembly_checker_tb.sv
// Self-checking testbench for the fragment reassembly checker: directed table and packets, then random
// packets, reads and starts under varied valid/ready idling. Depends on frc_pkg and the RTL.
`timescale 1ns / 1ps
`default_nettype none

module fragment_reassembly_checker_tb;
  import frc_pkg::*;

  localparam int DEPTH = 4096;
  localparam int MAX_WORDS = 4096;
  localparam int STALL_LIMIT = 20000;
  localparam logic [22:0] MODULUS = 23'd8388607;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  frc_in_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  frc_out_t rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [12:0] cfg_data = '0;

  always #2 clk = ~clk;

  fragment_reassembly_checker u_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Shadow state of the block.
  logic [12:0] mdl_len;
  int unsigned mdl_pos;
  logic [7:0] mdl_hdr [16];
  logic [22:0] mdl_acc;
  logic [31:0] mdl_word;
  logic [31:0] mdl_payload [MAX_WORDS];
  logic [31:0] mdl_store [DEPTH];
  logic [31:0] mdl_total;

  frc_out_t expected_q [$];
  int unsigned fail_count = 0;
  int unsigned sender_idle = 0;
  int unsigned receiver_stall = 0;
  bit hold_rsp = 1'b0;
  int unsigned quiet_cycles = 0;

  function automatic logic [13:0] hdr_offset();
    return {mdl_hdr[8], mdl_hdr[9][7:2]};
  endfunction

  function automatic logic [13:0] hdr_length();
    return {mdl_hdr[9][1:0], mdl_hdr[10], mdl_hdr[11][7:4]};
  endfunction

  function automatic int unsigned word_count();
    int unsigned len, w;
    len = hdr_length();
    w = (len < 16) ? 0 : (len - 16) / 4;
    return (w > MAX_WORDS) ? MAX_WORDS : w;
  endfunction

  function automatic logic [22:0] header_sum();
    logic [63:0] s;
    s = {mdl_hdr[0], mdl_hdr[1], mdl_hdr[2], mdl_hdr[3][7:4]};
    s += {mdl_hdr[3][3:0], mdl_hdr[4], mdl_hdr[5], mdl_hdr[6]};
    s += mdl_hdr[7][7:4];
    s += mdl_hdr[7][3:0];
    s += hdr_offset();
    s += hdr_length();
    s += {mdl_hdr[11][3:0], mdl_hdr[12][7]};
    s += mdl_hdr[15][7:6];
    s += mdl_hdr[15][5:0];
    return 23'(s % MODULUS);
  endfunction

  // Close the packet: verify checksum and range, commit words, update the total.
  function automatic void close_packet(int unsigned nwords, inout frc_out_t r);
    logic [22:0] calc, given;
    int unsigned lim, tgt, wr;
    calc = 23'((64'(header_sum()) + mdl_acc) % MODULUS);
    given = {mdl_hdr[12][6:0], mdl_hdr[13], mdl_hdr[14]};
    lim = (mdl_len > DEPTH) ? DEPTH : mdl_len;
    tgt = hdr_offset() / 4;
    wr = 0;
    r.computed_checksum = calc;
    if (calc != given) begin
      r.status = ST_CKERR;
    end else if (tgt >= lim) begin
      r.status = ST_RANGE;
    end else begin
      for (int k = 0; k < nwords && tgt + k < lim; k++) begin
        mdl_store[tgt + k] = mdl_payload[k];
        wr++;
      end
      r.status = ST_ACCEPT;
      if (mdl_total > 32'hFFFF_FFFF - wr) mdl_total = 32'hFFFF_FFFF;
      else mdl_total += wr;
    end
    r.words_written = 13'(wr);
    mdl_pos = 0;
    mdl_acc = '0;
    mdl_word = '0;
  endfunction

  // Advance the shadow state by one request item and return its result item.
  function automatic frc_out_t predict_reassembly(frc_in_t it);
    frc_out_t r;
    int unsigned rel, k, nw;
    logic [31:0] mag;
    r = '0;
    case (it.req_type)
      REQ_READ: begin
        r.status = ST_READ;
        r.read_data = mdl_store[it.read_index];
      end
      REQ_START: begin
        mdl_total = '0;
        mdl_pos = 0;
        mdl_acc = '0;
        mdl_word = '0;
      end
      REQ_BYTE: begin
        if (mdl_pos < 16) begin
          mdl_hdr[mdl_pos] = it.data_byte;
          if (mdl_pos == 15 && word_count() == 0) close_packet(0, r);
          else mdl_pos++;
        end else begin
          rel = mdl_pos - 16;
          k = rel >> 2;
          nw = word_count();
          mdl_word = {mdl_word[23:0], it.data_byte};
          if (rel[1:0] == 2'd3) begin
            mag = mdl_word[31] ? (~mdl_word + 32'd1) : mdl_word;
            if (k < MAX_WORDS) mdl_payload[k] = mdl_word;
            mdl_acc = 23'((64'(mdl_acc) + mag) % MODULUS);
            if (k + 1 >= nw) close_packet(nw, r);
            else mdl_pos++;
          end else begin
            mdl_pos++;
          end
        end
      end
      default: ;
    endcase
    r.total_written = mdl_total;
    return r;
  endfunction

  // Check each result item against the oldest expectation.
  always @(posedge clk) begin
    frc_out_t e;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_q.size() == 0) begin
        $error("result item with nothing expected");
        fail_count++;
      end else begin
        e = expected_q.pop_front();
        if (rsp.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, rsp.status); fail_count++;
        end
        if (rsp.words_written !== e.words_written) begin
          $error("words_written exp %0d got %0d", e.words_written, rsp.words_written);
          fail_count++;
        end
        if (rsp.total_written !== e.total_written) begin
          $error("total_written exp %0d got %0d", e.total_written, rsp.total_written);
          fail_count++;
        end
        if (rsp.computed_checksum !== e.computed_checksum) begin
          $error("computed_checksum exp %0h got %0h", e.computed_checksum,
                 rsp.computed_checksum);
          fail_count++;
        end
        if (rsp.read_data !== e.read_data) begin
          $error("read_data exp %0h got %0h", e.read_data, rsp.read_data); fail_count++;
        end
      end
    end
  end

  // Receiver: random stalls per phase, or a long hold-off when asked.
  always @(posedge clk) begin
    if (rst) rsp_ready <= 1'b0;
    else if (hold_rsp) rsp_ready <= 1'b0;
    else rsp_ready <= ($urandom_range(99) >= receiver_stall);
  end

  // Watchdog: count cycles without any accepted item. The post-reset sweep fits below it.
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready)
        || hold_rsp)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Offer one item; hold valid and payload until accepted. Idle gaps precede at random.
  task automatic send_item(frc_in_t it, bit check_typed = 1'b0, frc_out_t typed = '0);
    frc_out_t p;
    while ($urandom_range(99) < sender_idle) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= it;
    do @(posedge clk); while (!req_ready);
    p = predict_reassembly(it);
    if (check_typed) expected_q.push_back(typed);
    else expected_q.push_back(p);
  endtask

  task automatic drain_results();
    req_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_store_len(logic [12:0] v);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mdl_len = v;
  endtask

  function automatic frc_in_t byte_item(logic [7:0] b);
    frc_in_t it;
    it.req_type = REQ_BYTE;
    it.data_byte = b;
    it.read_index = 12'($urandom);
    return it;
  endfunction

  function automatic frc_in_t op_item(logic [1:0] kind, logic [11:0] idx);
    frc_in_t it;
    it.req_type = kind;
    it.data_byte = 8'($urandom);
    it.read_index = idx;
    return it;
  endfunction

  // Build and send one packet; good checksum unless corrupt is set.
  task automatic send_packet(int unsigned nwords, logic [13:0] offset, bit corrupt,
                             bit neg_heavy = 1'b0);
    logic [7:0] h [16];
    logic [31:0] w [$];
    logic [13:0] len;
    logic [63:0] s;
    logic [22:0] ck;
    logic [31:0] x;
    logic [31:0] mag;
    for (int i = 0; i < 16; i++) h[i] = 8'($urandom);
    len = 14'(16 + 4 * nwords + $urandom_range(3));
    if (nwords == 0) len = 14'($urandom_range(19));
    h[8] = offset[13:6];
    h[9] = {offset[5:0], len[13:12]};
    h[10] = len[11:4];
    h[11] = {len[3:0], h[11][3:0]};
    s = {h[0], h[1], h[2], h[3][7:4]};
    s += {h[3][3:0], h[4], h[5], h[6]};
    s += h[7][7:4] + h[7][3:0] + offset + len + {h[11][3:0], h[12][7]};
    s += h[15][7:6] + h[15][5:0];
    for (int i = 0; i < nwords; i++) begin
      x = $urandom;
      if (neg_heavy) x[31] = 1'b1;
      w.push_back(x);
      mag = x[31] ? (~x + 32'd1) : x;
      s += mag;
    end
    ck = 23'(s % MODULUS);
    if (corrupt) ck = 23'((64'(ck) + 1 + $urandom_range(1000)) % MODULUS);
    h[12] = {h[12][7], ck[22:16]};
    h[13] = ck[15:8];
    h[14] = ck[7:0];
    for (int i = 0; i < 16; i++) send_item(byte_item(h[i]));
    foreach (w[i])
      for (int j = 3; j >= 0; j--) send_item(byte_item(w[i][8*j +: 8]));
  endtask

  // Directed table: request item plus a typed result where it is obvious.
  typedef struct {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [11:0] idx;
    bit typed;
    frc_out_t result;
  } table_row_t;

  table_row_t rows [$];

  initial begin
    int unsigned n_items;
    int unsigned phase;
    frc_in_t row_item;
    mdl_len = 13'd4096;
    mdl_pos = 0;
    mdl_acc = '0;
    mdl_word = '0;
    mdl_total = '0;
    foreach (mdl_hdr[i]) mdl_hdr[i] = '0;
    foreach (mdl_store[i]) mdl_store[i] = '0;
    foreach (mdl_payload[i]) mdl_payload[i] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reads of the cleared store, start, the ignored request type, then an all-zero
    // header (length 0, checksum 0 matches, offset 0) which closes at header byte 15.
    rows.push_back('{REQ_READ, 8'h00, 12'd0, 1'b1, '{ST_READ, 13'd0, 32'd0, 23'd0, 32'sd0}});
    rows.push_back('{REQ_READ, 8'hFF, 12'd4095, 1'b1,
                     '{ST_READ, 13'd0, 32'd0, 23'd0, 32'sd0}});
    rows.push_back('{REQ_START, 8'hA5, 12'hFFF, 1'b1,
                     '{ST_PROGRESS, 13'd0, 32'd0, 23'd0, 32'sd0}});
    rows.push_back('{REQ_IGNORED, 8'hFF, 12'hFFF, 1'b1,
                     '{ST_PROGRESS, 13'd0, 32'd0, 23'd0, 32'sd0}});
    for (int i = 0; i < 15; i++)
      rows.push_back('{REQ_BYTE, 8'h00, 12'd0, 1'b1,
                       '{ST_PROGRESS, 13'd0, 32'd0, 23'd0, 32'sd0}});
    rows.push_back('{REQ_BYTE, 8'h00, 12'd0, 1'b1, '{ST_ACCEPT, 13'd0, 32'd0, 23'd0, 32'sd0}});
    foreach (rows[i]) begin
      row_item = '{rows[i].kind, rows[i].data_byte, rows[i].idx};
      send_item(row_item, rows[i].typed, rows[i].result);
    end

    // Directed packets: extremes of offset, negative words, bad checksum, out of range.
    send_packet(3, 14'd0, 1'b0, 1'b1);
    send_packet(2, 14'h3FFF, 1'b0);
    send_packet(2, 14'd8, 1'b1);
    send_item(op_item(REQ_READ, 12'd0));
    send_item(op_item(REQ_READ, 12'd2));
    write_store_len(13'd0);
    send_packet(1, 14'd0, 1'b0);
    write_store_len(13'd5);
    send_packet(4, 14'd12, 1'b0);
    send_item(op_item(REQ_READ, 12'd4));

    // Random phases: packets mostly well formed, with reads, starts and noise.
    n_items = 0;
    phase = 0;
    while (n_items < 750) begin
      case (phase % 4)
        0: begin sender_idle = 0; receiver_stall = 0; end
        1: begin sender_idle = 82; receiver_stall = 0; end
        2: begin sender_idle = 0; receiver_stall = 82; end
        default: begin sender_idle = 35; receiver_stall = 35; end
      endcase
      case (phase % 3)
        0: write_store_len(13'd4096);
        1: write_store_len(13'(1 + $urandom_range(40)));
        default: write_store_len(13'h1FFF);
      endcase
      for (int j = 0; j < 12; j++) begin
        int unsigned pick, nw;
        pick = $urandom_range(99);
        nw = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
        if (pick < 65) begin
          send_packet(nw, ($urandom_range(3) == 0) ? 14'($urandom) :
                      14'($urandom_range(0, 160)), ($urandom_range(5) == 0),
                      1'($urandom_range(1)));
          n_items += 16 + 4 * nw;
        end else if (pick < 80) begin
          send_item(op_item(REQ_READ, ($urandom_range(1)) ? 12'($urandom_range(60)) :
                            12'($urandom)));
          n_items++;
        end else if (pick < 85) begin
          send_item(op_item(REQ_START, 12'($urandom)));
          n_items++;
        end else if (pick < 88) begin
          send_item(op_item(REQ_IGNORED, 12'($urandom)));
          n_items++;
        end else begin
          // Broken sequence: random bytes, possibly mid-packet, then resync with a start.
          for (int b = $urandom_range(1, 20); b > 0; b--) send_item(byte_item(8'($urandom)));
          send_item(op_item(REQ_START, 12'($urandom)));
          n_items += 5;
        end
      end
      // Long receiver hold-off while items keep coming; then a full drain pause.
      if (phase == 1) begin
        sender_idle = 0;
        hold_rsp <= 1'b1;
        fork
          begin
            repeat (300) @(posedge clk);
            hold_rsp <= 1'b0;
          end
          send_packet(4, 14'd0, 1'b0);
        join
        drain_results();
      end
      phase++;
    end

    drain_results();
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire
